/* rtl/core/ssst_pkg.sv */
// ssst_pkg: shared types and constants of the substring search block.
// No dependencies; compiled first.
package ssst_pkg;

    localparam int DEFAULT_MAX_PATTERN   = 8;
    localparam int DEFAULT_POSITION_BITS = 16;

    localparam int BYTE_BITS      = 8;
    localparam int PATTERN_BITS   = 64;
    localparam int LENGTH_BITS    = 4;
    localparam int OUT_POS_BITS   = 16;
    localparam int COUNT_BITS     = 16;
    localparam int SINCE_BITS     = 4;
    localparam int CFG_INDEX_BITS = 1;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [SINCE_BITS-1:0] SINCE_IDLE = 4'd8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_BYTES  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 1'd1;

    typedef struct packed {
        logic [BYTE_BITS-1:0] data_byte;
        logic                 byte_present;
        logic                 last_item;
    } t_item;

    typedef struct packed {
        logic                    found;
        logic [OUT_POS_BITS-1:0] first_index;
        logic [OUT_POS_BITS-1:0] last_index;
        logic [COUNT_BITS-1:0]   match_count;
        logic                    starts_with;
        logic                    ends_with;
        logic                    too_long;
    } t_result;

endpackage

/* rtl/core/ssst_if.sv */
// ssst interfaces: valid/ready channels for input words, result words and config writes.
// Depends on ssst_pkg for field widths.
interface ssst_item_if;
    import ssst_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 byte_present;
    logic                 last_item;
    modport source (output valid, output data_byte, output byte_present, output last_item,
                    input ready);
    modport sink   (input valid, input data_byte, input byte_present, input last_item,
                    output ready);
endinterface

interface ssst_result_if;
    import ssst_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic [OUT_POS_BITS-1:0] first_index;
    logic [OUT_POS_BITS-1:0] last_index;
    logic [COUNT_BITS-1:0]   match_count;
    logic                    starts_with;
    logic                    ends_with;
    logic                    too_long;
    modport source (output valid, output found, output first_index, output last_index,
                    output match_count, output starts_with, output ends_with,
                    output too_long, input ready);
    modport sink   (input valid, input found, input first_index, input last_index,
                    input match_count, input starts_with, input ends_with,
                    input too_long, output ready);
endinterface

interface ssst_cfg_if;
    import ssst_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] wr_index;
    logic [PATTERN_BITS-1:0]   wr_data;
    modport source (output valid, output wr_index, output wr_data, input ready);
    modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

/* rtl/core/ssst_front.sv */
// ssst_front: accepts input words, drops words with no byte and no end mark,
// and queues the rest for the back end. Depends on ssst_pkg.
module ssst_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ssst_pkg::t_item i_item,
    output logic            o_q_valid,
    input  logic            i_q_ready,
    output ssst_pkg::t_item o_q_item
);
    import ssst_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_item            r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             push, pop;

    assign o_ready   = (r_cnt != CNT_FULL);
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_q[r_rd];

    always_comb begin
        push  = i_valid && o_ready && (i_item.byte_present || i_item.last_item);
        pop   = o_q_valid && i_q_ready;
        n_wr  = push ? ((r_wr == PTR_LAST) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd  = pop  ? ((r_rd == PTR_LAST) ? '0 : r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_item;
        end
    end

endmodule

/* rtl/core/ssst_back.sv */
// ssst_back: byte window, parallel pattern compare, match records and the
// result register. Depends on ssst_pkg.
module ssst_back #(
    parameter int MAX_PATTERN   = ssst_pkg::DEFAULT_MAX_PATTERN,
    parameter int POSITION_BITS = ssst_pkg::DEFAULT_POSITION_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [ssst_pkg::PATTERN_BITS-1:0]    i_pattern_bytes,
    input  logic [ssst_pkg::LENGTH_BITS-1:0]     i_pattern_length,
    input  logic                                 i_q_valid,
    output logic                                 o_q_ready,
    input  ssst_pkg::t_item                      i_q_item,
    output logic                                 o_res_valid,
    input  logic                                 i_res_ready,
    output ssst_pkg::t_result                    o_res
);
    import ssst_pkg::*;

    localparam int WIN_BITS  = BYTE_BITS * MAX_PATTERN;
    localparam int POS_W     = POSITION_BITS + 1;
    localparam int LEN_IDX_W = $clog2(MAX_PATTERN + 1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [LENGTH_BITS-1:0]   LEN_MAX = LENGTH_BITS'(MAX_PATTERN);

    logic [WIN_BITS-1:0]      r_window, n_window;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic [SINCE_BITS-1:0]    r_since, n_since;
    logic [POSITION_BITS-1:0] r_first, n_first;
    logic [POSITION_BITS-1:0] r_last, n_last;
    logic [COUNT_BITS-1:0]    r_total, n_total;
    logic                     r_any, n_any;
    logic                     r_prefix, n_prefix;
    logic                     r_out_valid;
    t_result                  r_out, res;

    logic [LENGTH_BITS-1:0]   eff_len;
    logic [LEN_IDX_W-1:0]     len_idx;
    logic [MAX_PATTERN:0]     len_hit;
    logic                     win_match, hit, fire;
    logic [POSITION_BITS-1:0] start, sat_pos;

    assign o_q_ready   = !r_out_valid || i_res_ready;
    assign fire        = i_q_valid && o_q_ready;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    assign eff_len = (i_pattern_length > LEN_MAX) ? LEN_MAX : i_pattern_length;
    assign len_idx = LEN_IDX_W'(eff_len);

    always_comb begin
        n_window = r_window;
        n_pos    = r_pos;
        n_since  = r_since;
        if (i_q_item.byte_present) begin
            if (MAX_PATTERN > 1) begin
                n_window = {r_window[WIN_BITS-BYTE_BITS-1:0], i_q_item.data_byte};
            end else begin
                n_window = WIN_BITS'(i_q_item.data_byte);
            end
            if (!r_pos[POSITION_BITS]) begin
                n_pos = r_pos + 1'b1;
            end
            if (r_since < SINCE_IDLE) begin
                n_since = r_since + 1'b1;
            end
        end
    end

    // one compare per possible pattern length; newest byte is the last pattern byte
    always_comb begin
        len_hit[0] = 1'b0;
        for (int k = 1; k <= MAX_PATTERN; k++) begin
            len_hit[k] = 1'b1;
            for (int i = 0; i < k; i++) begin
                if (i_pattern_bytes[BYTE_BITS*i +: BYTE_BITS] !=
                    n_window[BYTE_BITS*(k-1-i) +: BYTE_BITS]) begin
                    len_hit[k] = 1'b0;
                end
            end
        end
    end

    assign win_match = len_hit[len_idx] && (n_pos >= POS_W'(eff_len));
    assign hit       = i_q_item.byte_present && win_match;
    assign sat_pos   = n_pos[POSITION_BITS] ? POS_MAX : n_pos[POSITION_BITS-1:0];
    assign start     = n_pos[POSITION_BITS] ? POS_MAX
                     : n_pos[POSITION_BITS-1:0] - POSITION_BITS'(eff_len);

    always_comb begin
        n_first  = r_first;
        n_last   = r_last;
        n_total  = r_total;
        n_any    = r_any;
        n_prefix = r_prefix;
        if (hit) begin
            if (!r_any) begin
                n_first = start;
            end
            n_any  = 1'b1;
            n_last = start;
            if (n_since >= SINCE_BITS'(eff_len)) begin
                if (r_total != '1) begin
                    n_total = r_total + 1'b1;
                end
            end
            if (n_pos == POS_W'(eff_len)) begin
                n_prefix = 1'b1;
            end
        end
    end

    // counted matches reset the spacing count
    logic [SINCE_BITS-1:0] since_upd;
    assign since_upd = (hit && (n_since >= SINCE_BITS'(eff_len))) ? '0 : n_since;

    always_comb begin
        res.too_long = n_pos[POSITION_BITS];
        if (eff_len == '0) begin
            res.found       = 1'b1;
            res.first_index = '0;
            res.last_index  = OUT_POS_BITS'(sat_pos);
            res.match_count = '0;
            res.starts_with = 1'b1;
            res.ends_with   = 1'b1;
        end else begin
            res.found       = n_any;
            res.first_index = n_any ? OUT_POS_BITS'(n_first) : '0;
            res.last_index  = n_any ? OUT_POS_BITS'(n_last) : '0;
            res.match_count = n_total;
            res.starts_with = n_prefix;
            res.ends_with   = win_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_pos       <= '0;
            r_since     <= SINCE_IDLE;
            r_first     <= '0;
            r_last      <= '0;
            r_total     <= '0;
            r_any       <= 1'b0;
            r_prefix    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                if (i_q_item.last_item) begin
                    r_window <= '0;
                    r_pos    <= '0;
                    r_since  <= SINCE_IDLE;
                    r_first  <= '0;
                    r_last   <= '0;
                    r_total  <= '0;
                    r_any    <= 1'b0;
                    r_prefix <= 1'b0;
                end else begin
                    r_window <= n_window;
                    r_pos    <= n_pos;
                    r_since  <= since_upd;
                    r_first  <= n_first;
                    r_last   <= n_last;
                    r_total  <= n_total;
                    r_any    <= n_any;
                    r_prefix <= n_prefix;
                end
            end
            if (fire && i_q_item.last_item) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_q_item.last_item) begin
            r_out <= res;
        end
    end

endmodule

/* rtl/core/substring_search_stats.sv */
// substring_search_stats: streaming substring search with end-of-string statistics.
// The result word is registered in the back end when it takes the last word from the queue.
// Throughput: one input word per cycle; a waiting result word holds the back end.
// A two-word queue separates input acceptance from the compare stage.
// Reset (synchronous, active low) clears the string state, the queue and the pattern.
// Depends on ssst_pkg, ssst_if, ssst_front and ssst_back.
module substring_search_stats #(
    parameter int MAX_PATTERN   = ssst_pkg::DEFAULT_MAX_PATTERN,
    parameter int POSITION_BITS = ssst_pkg::DEFAULT_POSITION_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ssst_item_if.sink     i_item,
    ssst_result_if.source o_result,
    ssst_cfg_if.sink      i_cfg
);
    import ssst_pkg::*;

    logic [PATTERN_BITS-1:0] r_pattern_bytes;
    logic [LENGTH_BITS-1:0]  r_pattern_length;
    t_item                   in_item, q_item;
    t_result                 res;
    logic                    q_valid, q_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bytes  <= '0;
            r_pattern_length <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.wr_index)
                REG_PATTERN_BYTES:  r_pattern_bytes  <= i_cfg.wr_data;
                REG_PATTERN_LENGTH: r_pattern_length <= i_cfg.wr_data[LENGTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign in_item.data_byte    = i_item.data_byte;
    assign in_item.byte_present = i_item.byte_present;
    assign in_item.last_item    = i_item.last_item;

    ssst_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_item.valid),
        .o_ready   (i_item.ready),
        .i_item    (in_item),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_item  (q_item)
    );

    ssst_back #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pattern_bytes  (r_pattern_bytes),
        .i_pattern_length (r_pattern_length),
        .i_q_valid        (q_valid),
        .o_q_ready        (q_ready),
        .i_q_item         (q_item),
        .o_res_valid      (o_result.valid),
        .i_res_ready      (o_result.ready),
        .o_res            (res)
    );

    assign o_result.found       = res.found;
    assign o_result.first_index = res.first_index;
    assign o_result.last_index  = res.last_index;
    assign o_result.match_count = res.match_count;
    assign o_result.starts_with = res.starts_with;
    assign o_result.ends_with   = res.ends_with;
    assign o_result.too_long    = res.too_long;

endmodule

/* rtl/core/ssst_checker.sv */
// ssst_checker: port-level checks on result words of substring_search_stats.
// Depends on ssst_pkg; bound to the top level below.
module ssst_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              i_ready,
    input logic                              i_found,
    input logic [ssst_pkg::OUT_POS_BITS-1:0] i_first_index,
    input logic [ssst_pkg::OUT_POS_BITS-1:0] i_last_index,
    input logic [ssst_pkg::COUNT_BITS-1:0]   i_match_count,
    input logic                              i_starts_with,
    input logic                              i_ends_with,
    input logic                              i_too_long
);
    import ssst_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_found) && $stable(i_first_index)
            && $stable(i_last_index) && $stable(i_match_count) && $stable(i_too_long))
        else $error("result word changed while stalled");

    a_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_found |-> i_first_index == '0 && i_last_index == '0
            && i_match_count == '0)
        else $error("match records set without a match");

    a_implies_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_starts_with || i_ends_with || i_match_count != '0) |-> i_found)
        else $error("match flag set while found is clear");

    a_prefix_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_starts_with |-> i_first_index == '0)
        else $error("starts_with with nonzero first index");

endmodule

bind substring_search_stats ssst_checker u_ssst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_result.valid),
    .i_ready       (o_result.ready),
    .i_found       (o_result.found),
    .i_first_index (o_result.first_index),
    .i_last_index  (o_result.last_index),
    .i_match_count (o_result.match_count),
    .i_starts_with (o_result.starts_with),
    .i_ends_with   (o_result.ends_with),
    .i_too_long    (o_result.too_long)
);
